/* sv/hbg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbg_pkg
// Shared sizes, codes, types and helpers of the history bar graph renderer.
// ----------------------------------------------------------------------------
package hbg_pkg;

   localparam int MATRIX_WIDTH  = 13;
   localparam int MATRIX_HEIGHT = 8;
   localparam int HISTORY_DEPTH = 16;
   localparam int MAX_SHADE     = 7;
   localparam int METRIC_TOTAL  = 3;

   localparam int FULL_SCALE  = 25600;
   localparam int HALF_SCALE  = 12800;

   localparam int OP_W       = 1;
   localparam int METRIC_W   = 2;
   localparam int SAMPLE_W   = 16;
   localparam int COL_W      = 4;
   localparam int HEIGHT_W   = 4;
   localparam int SHADE_W    = 3;
   localparam int PIX_W      = 24;

   localparam int METRIC_IDX_W = (METRIC_TOTAL > 1) ? $clog2(METRIC_TOTAL) : 1;
   localparam int HEAD_W       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int COUNT_W      = $clog2(HISTORY_DEPTH + 1);
   localparam int ENTRIES      = METRIC_TOTAL * HISTORY_DEPTH;
   localparam int ADDR_W       = $clog2(ENTRIES);

   localparam logic signed [SAMPLE_W-1:0] INIT_SAMPLE = 16'sd1280;

   localparam logic [OP_W-1:0] OP_PUSH   = 1'b0;
   localparam logic [OP_W-1:0] OP_RENDER = 1'b1;

   typedef struct packed {
      logic                       we;
      logic [METRIC_W-1:0]        metric;
      logic signed [SAMPLE_W-1:0] sample;
   } hbg_push_type;

   typedef struct packed {
      logic                en;
      logic [METRIC_W-1:0] metric;
      logic [COL_W-1:0]    back;
   } hbg_read_type;

   // smallest sample that reaches bar height k
   function automatic int height_threshold(input int k);
      height_threshold = (k * FULL_SCALE - HALF_SCALE + MATRIX_HEIGHT - 1) / MATRIX_HEIGHT;
   endfunction

   // rounded rescale of brightness onto MAX_SHADE reduces to the clipped value
   function automatic logic [SHADE_W-1:0] lit_shade(input logic [SHADE_W-1:0] b);
      logic [SHADE_W-1:0] res;
      if (int'(b) > MAX_SHADE) begin
         res = SHADE_W'(MAX_SHADE);
      end else begin
         res = b;
      end
      lit_shade = res;
   endfunction

endpackage

/* sv/hbg_history.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbg_history
// Per-metric sample rings: storage, head and count, one registered read port.
// ----------------------------------------------------------------------------
module hbg_history (
   input  logic                                clock,
   input  logic                                reset,
   input  hbg_pkg::hbg_push_type               push,
   input  hbg_pkg::hbg_read_type               rd,
   output logic signed [hbg_pkg::SAMPLE_W-1:0] rd_sample
);

   localparam int WIDE_W = hbg_pkg::COUNT_W + hbg_pkg::COL_W;
   localparam int TMP_W  = hbg_pkg::HEAD_W + 1;

   logic signed [hbg_pkg::SAMPLE_W-1:0] mem [hbg_pkg::ENTRIES];
   logic [hbg_pkg::ENTRIES-1:0]         vld_ff;
   logic [hbg_pkg::HEAD_W-1:0]          head_ff  [hbg_pkg::METRIC_TOTAL];
   logic [hbg_pkg::COUNT_W-1:0]         count_ff [hbg_pkg::METRIC_TOTAL];

   logic                                push_ok;
   logic [hbg_pkg::METRIC_IDX_W-1:0]    pm;
   logic [hbg_pkg::ADDR_W-1:0]          waddr;
   logic [hbg_pkg::HEAD_W-1:0]          head_next;

   logic [hbg_pkg::METRIC_IDX_W-1:0]    rm;
   logic [hbg_pkg::COUNT_W-1:0]         rcount;
   logic [WIDE_W-1:0]                   back_cl;
   logic [TMP_W-1:0]                    tmp;
   logic [hbg_pkg::HEAD_W-1:0]          ridx;
   logic [hbg_pkg::ADDR_W-1:0]          raddr;

   logic signed [hbg_pkg::SAMPLE_W-1:0] mem_q;
   logic                                vld_q;
   logic                                empty_q;

   // write side
   always_comb begin
      push_ok = push.we && (int'(push.metric) < hbg_pkg::METRIC_TOTAL);
      pm      = push_ok ? push.metric[hbg_pkg::METRIC_IDX_W-1:0] : '0;
      waddr   = hbg_pkg::ADDR_W'(int'(pm) * hbg_pkg::HISTORY_DEPTH + int'(head_ff[pm]));
      if (int'(head_ff[pm]) == hbg_pkg::HISTORY_DEPTH - 1) begin
         head_next = '0;
      end else begin
         head_next = head_ff[pm] + hbg_pkg::HEAD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < hbg_pkg::METRIC_TOTAL; m++) begin
            head_ff[m]  <= hbg_pkg::HEAD_W'(hbg_pkg::MATRIX_WIDTH % hbg_pkg::HISTORY_DEPTH);
            count_ff[m] <= hbg_pkg::COUNT_W'((hbg_pkg::MATRIX_WIDTH < hbg_pkg::HISTORY_DEPTH)
                                             ? hbg_pkg::MATRIX_WIDTH : hbg_pkg::HISTORY_DEPTH);
         end
         vld_ff <= '0;
      end else if (push_ok) begin
         head_ff[pm] <= head_next;
         if (int'(count_ff[pm]) < hbg_pkg::HISTORY_DEPTH) begin
            count_ff[pm] <= count_ff[pm] + hbg_pkg::COUNT_W'(1);
         end
         vld_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[waddr] <= push.sample;
      end
   end

   // read side: newest minus back, clamped to oldest stored
   always_comb begin
      rm     = (int'(rd.metric) < hbg_pkg::METRIC_TOTAL) ? rd.metric[hbg_pkg::METRIC_IDX_W-1:0]
                                                         : '0;
      rcount = count_ff[rm];
      if (rcount == '0) begin
         back_cl = '0;
      end else if (WIDE_W'(rd.back) >= WIDE_W'(rcount)) begin
         back_cl = WIDE_W'(rcount) - WIDE_W'(1);
      end else begin
         back_cl = WIDE_W'(rd.back);
      end
      tmp = TMP_W'(head_ff[rm]) + TMP_W'(hbg_pkg::HISTORY_DEPTH - 1) - TMP_W'(back_cl);
      if (int'(tmp) >= hbg_pkg::HISTORY_DEPTH) begin
         tmp = tmp - TMP_W'(hbg_pkg::HISTORY_DEPTH);
      end
      ridx  = tmp[hbg_pkg::HEAD_W-1:0];
      raddr = hbg_pkg::ADDR_W'(int'(rm) * hbg_pkg::HISTORY_DEPTH + int'(ridx));
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         mem_q   <= mem[raddr];
         vld_q   <= vld_ff[raddr];
         empty_q <= (rcount == '0);
      end
   end

   always_comb begin
      priority if (empty_q) begin
         rd_sample = '0;
      end else if (vld_q) begin
         rd_sample = mem_q;
      end else begin
         rd_sample = hbg_pkg::INIT_SAMPLE;
      end
   end

endmodule

/* sv/hbg_column_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbg_column_unit
// Turns one sample into a bar height and the shaded pixels of one column.
// ----------------------------------------------------------------------------
module hbg_column_unit (
   input  logic signed [hbg_pkg::SAMPLE_W-1:0] sample,
   input  logic                                known,
   input  logic [hbg_pkg::SHADE_W-1:0]         shade,
   output logic [hbg_pkg::HEIGHT_W-1:0]        height,
   output logic [hbg_pkg::PIX_W-1:0]           pixels
);

   // rounded sample * height / full scale, as a count of crossed thresholds
   always_comb begin
      height = '0;
      if (known) begin
         for (int k = 1; k <= hbg_pkg::MATRIX_HEIGHT; k++) begin
            if (int'(sample) >= hbg_pkg::height_threshold(k)) begin
               height = height + hbg_pkg::HEIGHT_W'(1);
            end
         end
      end
   end

   // row 0 is the top row
   always_comb begin
      pixels = '0;
      for (int y = 0; y < hbg_pkg::MATRIX_HEIGHT; y++) begin
         if (y >= hbg_pkg::MATRIX_HEIGHT - int'(height)) begin
            pixels[hbg_pkg::SHADE_W*y +: hbg_pkg::SHADE_W] = shade;
         end
      end
   end

endmodule

/* sv/history_bar_graph_renderer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// history_bar_graph_renderer
// Per-metric sample history drawn as a column bar graph.
// ----------------------------------------------------------------------------
// Input words (req_*) are pushes or renders. A push stores req_sample in the
// ring of req_metric; a push to an unknown metric is dropped. A render emits
// one rsp_* word per matrix column, oldest on the left, rsp_last on the final
// column; an unknown metric renders empty bars. A render holds req_stall high
// while its column sequencer runs: one column per cycle while the output is
// not stalled, each doing one history read and one height/pixel pass through
// the shared column unit. Each column passes the sequencer's column register,
// the history read register with the first pipeline stage, then the output
// register. rsp_stall, while rsp_valid is high, freezes the column pipeline
// and the output word holds; nothing is dropped. csr_write_data sets the lit
// shade; the user must write it while idle, which the block does not enforce.
// Reset fills every ring with 5 percent, sets head and count to the matrix
// width and brightness to full; no clearing pass is needed.
// ----------------------------------------------------------------------------
module history_bar_graph_renderer (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [hbg_pkg::OP_W-1:0]            req_operation,
   input  logic [hbg_pkg::METRIC_W-1:0]        req_metric,
   input  logic signed [hbg_pkg::SAMPLE_W-1:0] req_sample,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [hbg_pkg::COL_W-1:0]           rsp_column,
   output logic [hbg_pkg::HEIGHT_W-1:0]        rsp_bar_height,
   output logic [hbg_pkg::PIX_W-1:0]           rsp_column_pixels,
   output logic                                rsp_last,

   input  logic                                csr_write_enable,
   input  logic [hbg_pkg::SHADE_W-1:0]         csr_write_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic [hbg_pkg::COL_W-1:0] LAST_COL = hbg_pkg::COL_W'(hbg_pkg::MATRIX_WIDTH - 1);

   logic                            state_ff, state_in;
   logic [hbg_pkg::COL_W-1:0]       col_ff, col_in;
   logic [hbg_pkg::METRIC_W-1:0]    metric_ff, metric_in;
   logic [hbg_pkg::SHADE_W-1:0]     brightness_ff;

   logic                            s1_valid_ff;
   logic [hbg_pkg::COL_W-1:0]       s1_col_ff;
   logic                            s1_known_ff;

   logic                            rsp_valid_ff;
   logic [hbg_pkg::COL_W-1:0]       rsp_column_ff;
   logic [hbg_pkg::HEIGHT_W-1:0]    rsp_bar_height_ff;
   logic [hbg_pkg::PIX_W-1:0]       rsp_column_pixels_ff;
   logic                            rsp_last_ff;

   logic                            req_accept;
   logic                            advance;
   logic                            issue;
   hbg_pkg::hbg_push_type           push;
   hbg_pkg::hbg_read_type           rd;
   logic signed [hbg_pkg::SAMPLE_W-1:0] rd_sample;
   logic [hbg_pkg::HEIGHT_W-1:0]    cu_height;
   logic [hbg_pkg::PIX_W-1:0]       cu_pixels;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign issue      = (state_ff == ST_RUN);

   assign push.we     = req_accept && (req_operation == hbg_pkg::OP_PUSH);
   assign push.metric = req_metric;
   assign push.sample = req_sample;

   assign rd.en     = advance;
   assign rd.metric = metric_ff;
   assign rd.back   = LAST_COL - col_ff;

   hbg_history u_history (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rd        (rd),
      .rd_sample (rd_sample)
   );

   hbg_column_unit u_column_unit (
      .sample (rd_sample),
      .known  (s1_known_ff),
      .shade  (hbg_pkg::lit_shade(brightness_ff)),
      .height (cu_height),
      .pixels (cu_pixels)
   );

   // column sequencer
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      metric_in = metric_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_operation == hbg_pkg::OP_RENDER)) begin
               state_in  = ST_RUN;
               col_in    = '0;
               metric_in = req_metric;
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (col_ff == LAST_COL) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in = col_ff + hbg_pkg::COL_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         metric_ff     <= '0;
         brightness_ff <= hbg_pkg::SHADE_W'(7);
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         col_ff    <= col_in;
         metric_ff <= metric_in;
         if (csr_write_enable) begin
            brightness_ff <= csr_write_data;
         end
         if (advance) begin
            s1_valid_ff  <= issue;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_col_ff   <= col_ff;
         s1_known_ff <= (int'(metric_ff) < hbg_pkg::METRIC_TOTAL);
         if (s1_valid_ff) begin
            rsp_column_ff        <= s1_col_ff;
            rsp_bar_height_ff    <= cu_height;
            rsp_column_pixels_ff <= cu_pixels;
            rsp_last_ff          <= (s1_col_ff == LAST_COL);
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column        = rsp_column_ff;
   assign rsp_bar_height    = rsp_bar_height_ff;
   assign rsp_column_pixels = rsp_column_pixels_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_column_ff == LAST_COL)
      else $error("last flag on wrong column");

   a_height_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> int'(rsp_bar_height_ff) <= hbg_pkg::MATRIX_HEIGHT)
      else $error("bar height out of range");

   a_empty_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bar_height_ff == '0 |-> rsp_column_pixels_ff == '0)
      else $error("pixels lit on empty bar");

   a_render_start: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_operation == hbg_pkg::OP_RENDER |=> state_ff == ST_RUN && col_ff == '0)
      else $error("render did not start at column zero");
`endif

endmodule
